FILE: design/mfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel feedback queue package
// Shared codes, sizes and control structures of the queue unit.
// ----------------------------------------------------------------------------
package mfq_pkg;

    // Fixed sizes.
    localparam int NUM_QUEUES      = 9;
    localparam int QNUM_W          = 4;
    localparam int LEVELS          = 3;
    localparam int MAX_VISITS      = 2;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    // Operation requested by an item.
    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_SUSPEND  = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_VISITS = 2'd3
    } t_status;

    // Memory strobes from the controller to the entry store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

    // Decoded result of one item, waiting on the memory read.
    typedef struct packed {
        t_status            status;
        logic [QNUM_W-1:0]  queue;
        logic               pop;
    } t_result;

endpackage : mfq_pkg
`default_nettype wire

FILE: design/mfq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Queue controller
// Keeps head pointers and fill counts, picks the queue for each item and
// issues the entry store access.
// ----------------------------------------------------------------------------
module mfq_ctrl
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic [1:0]         i_kind,
    input  wire logic [7:0]         i_pid,
    input  wire logic [3:0]         i_prio,
    input  wire logic [1:0]         i_visits,
    output      t_result            o_res,
    output      t_mem_cmd           o_mem,
    output      logic [QNUM_W-1:0]  o_mem_q,
    output      logic [PTR_W-1:0]   o_mem_slot,
    output      logic [ID_BITS-1:0] o_mem_wdata
);

    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0]  r_head  [NUM_QUEUES];
    logic [CNT_W-1:0]  r_count [NUM_QUEUES];
    logic [PTR_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;
    logic              w_upd;

    logic [NUM_QUEUES-1:0] w_nonempty;
    logic [QNUM_W-1:0]     w_first;
    logic [QNUM_W-1:0]     w_last;
    logic [QNUM_W-1:0]     w_q_ins;
    logic [QNUM_W-1:0]     w_q;
    logic [1:0]            w_level;
    logic [PTR_W-1:0]      w_head;
    logic [CNT_W-1:0]      w_cnt;
    logic [CNT_W-1:0]      w_off;
    logic [SUM_W-1:0]      w_sum;
    logic [SUM_W-1:0]      w_wrap;
    logic [PTR_W-1:0]      w_head_inc;
    logic [15:0]           w_pid_ext;
    logic                  w_any;
    logic                  w_bad_visits;
    logic                  w_full;

    // Occupancy flags and the lowest and highest occupied queues.
    always_comb begin
        w_first = '0;
        w_last  = '0;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            w_nonempty[i] = (r_count[i] != '0);
        end
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
            if (w_nonempty[i]) begin
                w_first = QNUM_W'(i);
            end
        end
        for (int i = 0; i < NUM_QUEUES; i++) begin
            if (w_nonempty[i]) begin
                w_last = QNUM_W'(i);
            end
        end
    end

    assign w_any = |w_nonempty;

    // Insert target: level from the priority plus three per CPU visit.
    always_comb begin
        priority case (i_prio)
            4'd2:    w_level = 2'd1;
            4'd3:    w_level = 2'd2;
            default: w_level = 2'd0;
        endcase
    end

    assign w_bad_visits = (i_visits > 2'(MAX_VISITS));
    assign w_q_ins      = QNUM_W'(w_level) + QNUM_W'(LEVELS) * QNUM_W'(i_visits);

    // Queue selected by the operation; only this one is read and updated.
    always_comb begin
        unique case (t_kind'(i_kind))
            KIND_INSERT:   w_q = w_bad_visits ? '0 : w_q_ins;
            KIND_DISPATCH: w_q = w_first;
            KIND_SUSPEND:  w_q = w_last;
            default:       w_q = '0;
        endcase
    end

    assign w_head = r_head[w_q];
    assign w_cnt  = r_count[w_q];
    assign w_full = (w_cnt >= CNT_W'(QUEUE_DEPTH));

    // Slot of the addressed entry, wrapped once around the circular buffer.
    always_comb begin
        unique case (t_kind'(i_kind))
            KIND_INSERT:  w_off = w_cnt;
            KIND_SUSPEND: w_off = w_cnt - CNT_W'(1);
            default:      w_off = '0;
        endcase
    end

    assign w_sum  = SUM_W'(w_head) + SUM_W'(w_off);
    assign w_wrap = (w_sum >= SUM_W'(QUEUE_DEPTH)) ? (w_sum - SUM_W'(QUEUE_DEPTH)) : w_sum;
    assign w_head_inc = (w_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (w_head + PTR_W'(1));

    // Identifier kept to ID_BITS bits.
    assign w_pid_ext   = {8'd0, i_pid};
    assign o_mem_wdata = w_pid_ext[ID_BITS-1:0];
    assign o_mem_q     = w_q;
    assign o_mem_slot  = w_wrap[PTR_W-1:0];

    // Decode the operation into a result, a memory access and a state update.
    always_comb begin
        o_res.status = ST_OK;
        o_res.queue  = '0;
        o_res.pop    = 1'b0;
        o_mem.wr_en  = 1'b0;
        o_mem.rd_en  = 1'b0;
        w_upd        = 1'b0;
        n_head       = w_head;
        n_count      = w_cnt;
        unique case (t_kind'(i_kind))
            KIND_INSERT: begin
                if (w_bad_visits) begin
                    o_res.status = ST_VISITS;
                end else if (w_full) begin
                    o_res.status = ST_FULL;
                    o_res.queue  = w_q;
                end else begin
                    o_res.queue = w_q;
                    o_mem.wr_en = i_adv;
                    w_upd       = 1'b1;
                    n_count     = w_cnt + CNT_W'(1);
                end
            end
            KIND_DISPATCH: begin
                if (!w_any) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.queue = w_q;
                    o_res.pop   = 1'b1;
                    o_mem.rd_en = i_adv;
                    w_upd       = 1'b1;
                    n_head      = w_head_inc;
                    n_count     = w_cnt - CNT_W'(1);
                end
            end
            KIND_SUSPEND: begin
                if (!w_any) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.queue = w_q;
                    o_res.pop   = 1'b1;
                    o_mem.rd_en = i_adv;
                    w_upd       = 1'b1;
                    n_count     = w_cnt - CNT_W'(1);
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
    end

    // Pointer and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_adv && w_upd) begin
            r_head[w_q]  <= n_head;
            r_count[w_q] <= n_count;
        end
    end

endmodule : mfq_ctrl
`default_nettype wire

FILE: design/mfq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Entry store
// One circular buffer of identifiers per queue, with a registered read.
// ----------------------------------------------------------------------------
module mfq_store
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
    input  wire logic               i_clk,
    input  wire t_mem_cmd           i_mem,
    input  wire logic [QNUM_W-1:0]  i_q,
    input  wire logic [PTR_W-1:0]   i_slot,
    input  wire logic [ID_BITS-1:0] i_wdata,
    output      logic [ID_BITS-1:0] o_rdata
);

    logic [ID_BITS-1:0] r_mem [NUM_QUEUES][QUEUE_DEPTH];
    logic [ID_BITS-1:0] r_rdata;

    // Single-port access: one write or one read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_q][i_slot] <= i_wdata;
        end
        if (i_mem.rd_en) begin
            r_rdata <= r_mem[i_q][i_slot];
        end
    end

    assign o_rdata = r_rdata;

endmodule : mfq_store
`default_nettype wire

FILE: design/multilevel_feedback_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel feedback queue unit
// Nine FIFO queues of process identifiers with insert, dispatch and suspend.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the output is not stalled and
// returns exactly one result per item: the item passes through the input
// register, where the controller picks the queue and updates its head pointer
// and count while the entry store is written or read, and then the result
// register, which is loaded together with the registered read of the entry
// store. Items of any kind may follow each other back to back; a stalled output
// holds the pipeline. The entry store needs no clearing after reset.
module multilevel_feedback_queue_unit
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // tdata: kind[1:0], process_id[9:2], priority_req[13:10], cpu_visits[15:14]
    input  wire logic [15:0] s_axis_tdata,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: status[1:0], out_process_id[9:2], queue_number[13:10], zero[15:14]
    output      logic [15:0] m_axis_tdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic        r_a_vld;
    logic [1:0]  r_a_kind;
    logic [7:0]  r_a_pid;
    logic [3:0]  r_a_prio;
    logic [1:0]  r_a_visits;
    logic        r_b_vld;
    t_result     r_b_res;

    logic               w_adv;
    logic               w_in_acc;
    t_result            w_res;
    t_mem_cmd           w_mem;
    logic [QNUM_W-1:0]  w_mem_q;
    logic [PTR_W-1:0]   w_mem_slot;
    logic [ID_BITS-1:0] w_mem_wdata;
    logic [ID_BITS-1:0] w_rdata;
    logic [15:0]        w_rdata_ext;
    logic [7:0]         w_out_id;

    // Pipeline flow control.
    assign w_adv         = r_a_vld && (!r_b_vld || m_axis_tready);
    assign s_axis_tready = !r_a_vld || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_kind   <= s_axis_tdata[1:0];
            r_a_pid    <= s_axis_tdata[9:2];
            r_a_prio   <= s_axis_tdata[13:10];
            r_a_visits <= s_axis_tdata[15:14];
        end
    end

    mfq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_kind      (r_a_kind),
        .i_pid       (r_a_pid),
        .i_prio      (r_a_prio),
        .i_visits    (r_a_visits),
        .o_res       (w_res),
        .o_mem       (w_mem),
        .o_mem_q     (w_mem_q),
        .o_mem_slot  (w_mem_slot),
        .o_mem_wdata (w_mem_wdata)
    );

    mfq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_mem   (w_mem),
        .i_q     (w_mem_q),
        .i_slot  (w_mem_slot),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // Result register; the popped identifier arrives with it from the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_adv) begin
            r_b_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_res <= w_res;
        end
    end

    // Output packing.
    assign w_rdata_ext   = 16'(w_rdata);
    assign w_out_id      = r_b_res.pop ? w_rdata_ext[7:0] : 8'd0;
    assign m_axis_tvalid = r_b_vld;
    assign m_axis_tdata  = {2'b00, r_b_res.queue, w_out_id, r_b_res.status};

    // A successful pop always reports an OK status.
    a_pop_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_res.pop) |-> (r_b_res.status == ST_OK))
        else $error("pop result with non-ok status");

    // Reported queue numbers stay inside the nine queues.
    a_queue_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:10] < 4'(NUM_QUEUES)))
        else $error("queue number out of range");

    // Rejected visit counts and empty pops touch no queue.
    a_no_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && (r_b_res.status == ST_VISITS || r_b_res.status == ST_EMPTY))
        |-> (r_b_res.queue == '0 && !r_b_res.pop))
        else $error("rejected item reports a queue");

    // An accepted item occupies the input register in the next cycle.
    a_accept_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_a_vld)
        else $error("accepted item lost");

endmodule : multilevel_feedback_queue_unit
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multilevel feedback queue unit testbench
// Drives inserts, dispatches, suspends and the unused kind over the input stream.
// It checks every result field against a prediction from its own copy of the nine
// queues, or against a typed row's own result, while both sides stall at random.
// ----------------------------------------------------------------------------
module tb
    import mfq_pkg::*;
();

    localparam int         QDEPTH      = DEF_QUEUE_DEPTH;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One operation as it travels on the input stream.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pid;
        logic [3:0] prio;
        logic [1:0] visits;
    } t_sched_item;

    // One result as it travels on the output stream.
    typedef struct packed {
        t_status    status;
        logic [7:0] pid;
        logic [3:0] qnum;
    } t_sched_result;

    // One row of the directed table; typed rows carry their own result.
    typedef struct packed {
        t_sched_item   item;
        logic [7:0]    reps;
        logic          typed;
        t_sched_result res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: kind[1:0], process_id[9:2], priority_req[13:10], cpu_visits[15:14]
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: status[1:0], out_process_id[9:2], queue_number[13:10], zero[15:14]
    logic [15:0] m_axis_tdata;

    // Shadow copy of the queues used for prediction.
    logic [7:0]    pid_ring [NUM_QUEUES][QDEPTH];
    int            ring_head [NUM_QUEUES];
    int            ring_fill [NUM_QUEUES];

    t_sched_result pending_results [$];
    t_stim_row     directed_rows [$];
    int            idle_pct;
    int            fail_count = 0;

    multilevel_feedback_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Applies one operation to the shadow queues and returns its result.
    function automatic t_sched_result schedule_step(input t_sched_item it);
        t_sched_result r;
        int            q;
        int            level;
        bit            done;
        r.status = ST_OK;
        r.pid    = '0;
        r.qnum   = '0;
        done     = 1'b0;
        case (it.kind)
            KIND_INSERT: begin
                if (it.visits > MAX_VISITS) begin
                    r.status = ST_VISITS;
                end else begin
                    level  = (it.prio == 4'd2) ? 1 : (it.prio == 4'd3) ? 2 : 0;
                    q      = level + LEVELS * int'(it.visits);
                    r.qnum = 4'(q);
                    if (ring_fill[q] >= QDEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        pid_ring[q][(ring_head[q] + ring_fill[q]) % QDEPTH] = it.pid;
                        ring_fill[q]++;
                    end
                end
            end
            KIND_DISPATCH: begin
                // Head of the lowest-numbered queue that holds anything.
                for (q = 0; q < NUM_QUEUES; q++) begin
                    if (!done && ring_fill[q] != 0) begin
                        r.pid        = pid_ring[q][ring_head[q]];
                        r.qnum       = 4'(q);
                        ring_head[q] = (ring_head[q] + 1) % QDEPTH;
                        ring_fill[q]--;
                        done         = 1'b1;
                    end
                end
                if (!done) r.status = ST_EMPTY;
            end
            KIND_SUSPEND: begin
                // Tail of the highest-numbered queue that holds anything.
                for (q = NUM_QUEUES - 1; q >= 0; q--) begin
                    if (!done && ring_fill[q] != 0) begin
                        r.pid  = pid_ring[q][(ring_head[q] + ring_fill[q] - 1) % QDEPTH];
                        r.qnum = 4'(q);
                        ring_fill[q]--;
                        done   = 1'b1;
                    end
                end
                if (!done) r.status = ST_EMPTY;
            end
            default: begin
                // The unused kind leaves every queue alone.
            end
        endcase
        return r;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(input logic [1:0] kind, input logic [7:0] pid,
                           input logic [3:0] prio, input logic [1:0] visits,
                           input int reps, input bit typed, input t_status st,
                           input logic [7:0] opid, input logic [3:0] q);
        t_stim_row row;
        row.item.kind   = kind;
        row.item.pid    = pid;
        row.item.prio   = prio;
        row.item.visits = visits;
        row.reps        = 8'(reps);
        row.typed       = typed;
        row.res.status  = st;
        row.res.pid     = opid;
        row.res.qnum    = q;
        directed_rows.push_back(row);
    endtask

    // Offers one item after a random gap and records its expected result once
    // it is taken. Called and left at a falling edge.
    task automatic send_item(input t_sched_item it, input bit typed,
                             input t_sched_result typed_res);
        t_sched_result predicted;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.visits, it.prio, it.pid, it.kind};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = schedule_step(it);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // Result side: random back pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status,
                           m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[9:2] != want.pid) begin
                    $error("out_process_id: expected %0d, actual %0d", want.pid,
                           m_axis_tdata[9:2]);
                    fail_count++;
                end
                if (m_axis_tdata[13:10] != want.qnum) begin
                    $error("queue_number: expected %0d, actual %0d", want.qnum,
                           m_axis_tdata[13:10]);
                    fail_count++;
                end
            end
        end
    end

    // Run limit.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Main sequence.
    initial begin
        t_sched_item   it;
        t_sched_result no_res;
        int            ins_pct;
        int            focus_lvl;
        int            focus_vis;
        bit            focus;
        int            roll;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_pct      = 10;
        no_res        = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            ring_head[q] = 0;
            ring_fill[q] = 0;
        end

        // Directed table: empty pops, unused kind, visit limit, field
        // extremes, every level and visit count, one queue filled past full.
        add_row(KIND_DISPATCH, 8'h00, 4'h0, 2'd0, 1, 1, ST_EMPTY, 8'h00, 4'd0);
        add_row(KIND_SUSPEND,  8'h00, 4'h0, 2'd0, 1, 1, ST_EMPTY, 8'h00, 4'd0);
        add_row(KIND_UNUSED,   8'hFF, 4'hF, 2'd3, 1, 1, ST_OK,    8'h00, 4'd0);
        add_row(KIND_INSERT,   8'hAA, 4'h0, 2'd3, 1, 1, ST_VISITS, 8'h00, 4'd0);
        add_row(KIND_INSERT,   8'hFF, 4'hF, 2'd2, 1, 1, ST_OK,    8'h00, 4'd6);
        add_row(KIND_INSERT,   8'h00, 4'h2, 2'd0, 1, 1, ST_OK,    8'h00, 4'd1);
        add_row(KIND_INSERT,   8'h5A, 4'h3, 2'd2, 1, 1, ST_OK,    8'h00, 4'd8);
        add_row(KIND_INSERT,   8'h33, 4'h3, 2'd0, 1, 1, ST_OK,    8'h00, 4'd2);
        add_row(KIND_INSERT,   8'h44, 4'h0, 2'd1, 1, 1, ST_OK,    8'h00, 4'd3);
        add_row(KIND_INSERT,   8'h80, 4'h2, 2'd1, QDEPTH, 0, ST_OK, 8'h00, 4'd0);
        add_row(KIND_INSERT,   8'h01, 4'h2, 2'd1, 1, 1, ST_FULL,  8'h00, 4'd4);
        add_row(KIND_INSERT,   8'h77, 4'h3, 2'd1, 1, 1, ST_OK,    8'h00, 4'd5);
        add_row(KIND_INSERT,   8'hC3, 4'h1, 2'd2, 1, 1, ST_OK,    8'h00, 4'd6);
        add_row(KIND_DISPATCH, 8'h00, 4'h0, 2'd0, 3, 0, ST_OK,    8'h00, 4'd0);
        add_row(KIND_SUSPEND,  8'h00, 4'h0, 2'd0, 3, 0, ST_OK,    8'h00, 4'd0);
        add_row(KIND_INSERT,   8'h9C, 4'h7, 2'd0, 1, 1, ST_OK,    8'h00, 4'd0);
        add_row(KIND_DISPATCH, 8'h00, 4'h0, 2'd0, 2, 0, ST_OK,    8'h00, 4'd0);

        // Hold the synchronous reset, then release it at a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table.
        foreach (directed_rows[r]) begin
            for (int i = 0; i < directed_rows[r].reps; i++) begin
                it     = directed_rows[r].item;
                it.pid = it.pid + 8'(i);
                send_item(it, directed_rows[r].typed, directed_rows[r].res);
            end
        end

        // Random bursts: each leans toward filling, draining or neither, and some aim
        // their inserts at one queue so that it can run full.
        for (int b = 0; b < 16; b++) begin
            case ($urandom_range(3))
                0:       ins_pct = 15;
                1:       ins_pct = 50;
                2:       ins_pct = 80;
                default: ins_pct = 95;
            endcase
            focus     = ($urandom_range(9) < 3);
            focus_lvl = $urandom_range(2);
            focus_vis = $urandom_range(2);
            idle_pct  = (b >= 6 && b < 9) ? 0 : 10;
            for (int n = 0; n < 100; n++) begin
                it.pid    = 8'($urandom_range(255));
                it.prio   = 4'($urandom_range(15));
                it.visits = 2'($urandom_range(2));
                roll      = $urandom_range(99);
                if (roll < 2) begin
                    it.kind   = KIND_UNUSED;
                    it.visits = 2'($urandom_range(3));
                end else if ($urandom_range(99) < ins_pct) begin
                    it.kind = KIND_INSERT;
                    if (focus) begin
                        if (focus_lvl == 1) begin
                            it.prio = 4'd2;
                        end else if (focus_lvl == 2) begin
                            it.prio = 4'd3;
                        end else if (it.prio == 4'd2 || it.prio == 4'd3) begin
                            it.prio = it.prio ^ 4'h8;
                        end
                        it.visits = 2'(focus_vis);
                    end else begin
                        roll = $urandom_range(9);
                        if (roll < 3) it.prio = 4'd2;
                        else if (roll < 6) it.prio = 4'd3;
                    end
                    if ($urandom_range(99) < 5) it.visits = 2'd3;
                end else begin
                    it.kind = $urandom_range(1) ? KIND_DISPATCH : KIND_SUSPEND;
                end
                send_item(it, 1'b0, no_res);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency to pass.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
